// ===== hdl/acdp_pkg.sv =====
// ----------------------------------------------------------------------------
// acdp_pkg
// Types and constants shared by the data-processing execute pipeline.
// ----------------------------------------------------------------------------
package acdp_pkg;

   localparam int FLAG_N = 3;
   localparam int FLAG_Z = 2;
   localparam int FLAG_C = 1;
   localparam int FLAG_V = 0;

   localparam int REQ_BITS = 132;
   localparam int RSP_BITS = 43;

   typedef enum logic [3:0] {
      OP_AND = 4'd0,
      OP_EOR = 4'd1,
      OP_SUB = 4'd2,
      OP_RSB = 4'd3,
      OP_ADD = 4'd4,
      OP_ADC = 4'd5,
      OP_SBC = 4'd6,
      OP_RSC = 4'd7,
      OP_TST = 4'd8,
      OP_TEQ = 4'd9,
      OP_CMP = 4'd10,
      OP_CMN = 4'd11,
      OP_ORR = 4'd12,
      OP_MOV = 4'd13,
      OP_BIC = 4'd14,
      OP_MVN = 4'd15
   } alu_op_type;

   typedef enum logic [1:0] {
      SH_LSL = 2'd0,
      SH_LSR = 2'd1,
      SH_ASR = 2'd2,
      SH_ROR = 2'd3
   } shift_kind_type;

   // input transaction, instruction in the lowest bits
   typedef struct packed {
      logic [3:0]  flags_in;
      logic [31:0] rs_value;
      logic [31:0] rm_value;
      logic [31:0] rn_value;
      logic [31:0] instruction;
   } req_type;

   // result transaction, not_data_processing in the lowest bit
   typedef struct packed {
      logic [3:0]  flags_out;
      logic [3:0]  dest_index;
      logic        write_dest;
      logic [31:0] result_value;
      logic        executed;
      logic        not_data_processing;
   } rsp_type;

   // decode -> shifter
   typedef struct packed {
      logic           dp;
      logic           exec;
      alu_op_type     op;
      logic           s;
      logic [3:0]     rd;
      logic [3:0]     flags;
      logic [31:0]    rn;
      logic [31:0]    rm;
      logic           imm;
      logic [7:0]     imm8;
      logic [3:0]     rot;
      shift_kind_type kind;
      logic           reg_sh;
      logic [7:0]     amt;
   } dec_type;

   // shifter -> alu
   typedef struct packed {
      logic        dp;
      logic        exec;
      alu_op_type  op;
      logic        s;
      logic [3:0]  rd;
      logic [3:0]  flags;
      logic [31:0] rn;
      logic [31:0] op2;
      logic        sc;
   } opnd_type;

endpackage

// ===== hdl/acdp_decode.sv =====
// ----------------------------------------------------------------------------
// acdp_decode
// Stage 1: encoding class check, condition test, operand 2 field extraction.
// ----------------------------------------------------------------------------
module acdp_decode (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  acdp_pkg::req_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output acdp_pkg::dec_type out_data
);

   typedef enum logic [3:0] {
      COND_EQ = 4'd0,
      COND_NE = 4'd1,
      COND_CS = 4'd2,
      COND_CC = 4'd3,
      COND_MI = 4'd4,
      COND_PL = 4'd5,
      COND_VS = 4'd6,
      COND_VC = 4'd7,
      COND_HI = 4'd8,
      COND_LS = 4'd9,
      COND_GE = 4'd10,
      COND_LT = 4'd11,
      COND_GT = 4'd12,
      COND_LE = 4'd13,
      COND_AL = 4'd14,
      COND_NV = 4'd15
   } cond_type;

   logic              valid_ff;
   logic              valid_in;
   acdp_pkg::dec_type data_ff;
   acdp_pkg::dec_type data_in;
   logic              pass;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;
   assign valid_in  = in_ready ? in_valid : valid_ff;

   always_comb begin
      logic n, z, c, v;
      n = in_data.flags_in[acdp_pkg::FLAG_N];
      z = in_data.flags_in[acdp_pkg::FLAG_Z];
      c = in_data.flags_in[acdp_pkg::FLAG_C];
      v = in_data.flags_in[acdp_pkg::FLAG_V];
      unique case (cond_type'(in_data.instruction[31:28]))
         COND_EQ: pass = z;
         COND_NE: pass = !z;
         COND_CS: pass = c;
         COND_CC: pass = !c;
         COND_MI: pass = n;
         COND_PL: pass = !n;
         COND_VS: pass = v;
         COND_VC: pass = !v;
         COND_HI: pass = c && !z;
         COND_LS: pass = !c || z;
         COND_GE: pass = (n == v);
         COND_LT: pass = (n != v);
         COND_GT: pass = !z && (n == v);
         COND_LE: pass = z || (n != v);
         COND_AL: pass = 1'b1;
         COND_NV: pass = 1'b0;
         default: pass = 1'b0;
      endcase
   end

   always_comb begin
      logic [31:0]          insn;
      acdp_pkg::alu_op_type op;
      logic                 dp;
      insn = in_data.instruction;
      op   = acdp_pkg::alu_op_type'(insn[24:21]);
      dp   = (insn[27:26] == 2'b00);
      // multiply / swap / halfword space
      if (!insn[25] && insn[4] && insn[7]) begin
         dp = 1'b0;
      end
      // status register / branch-exchange space: compare ops without S
      if (!insn[20] && (op inside {acdp_pkg::OP_TST, acdp_pkg::OP_TEQ,
                                   acdp_pkg::OP_CMP, acdp_pkg::OP_CMN})) begin
         dp = 1'b0;
      end
      data_in.dp     = dp;
      data_in.exec   = dp && pass;
      data_in.op     = op;
      data_in.s      = insn[20];
      data_in.rd     = insn[15:12];
      data_in.flags  = in_data.flags_in;
      data_in.rn     = in_data.rn_value;
      data_in.rm     = in_data.rm_value;
      data_in.imm    = insn[25];
      data_in.imm8   = insn[7:0];
      data_in.rot    = insn[11:8];
      data_in.kind   = acdp_pkg::shift_kind_type'(insn[6:5]);
      data_in.reg_sh = insn[4];
      data_in.amt    = insn[4] ? in_data.rs_value[7:0] : {3'b000, insn[11:7]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== hdl/acdp_shift.sv =====
// ----------------------------------------------------------------------------
// acdp_shift
// Stage 2: barrel shifter, forms operand 2 and the shifter carry.
// ----------------------------------------------------------------------------
module acdp_shift (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  acdp_pkg::dec_type  in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output acdp_pkg::opnd_type out_data
);

   logic               valid_ff;
   logic               valid_in;
   acdp_pkg::opnd_type data_ff;
   acdp_pkg::opnd_type data_in;
   logic [31:0]        op2;
   logic               sc;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;
   assign valid_in  = in_ready ? in_valid : valid_ff;

   always_comb begin
      logic [31:0]        rm;
      logic               cin;
      logic [4:0]         a5;
      logic [32:0]        lsl_w;
      logic [32:0]        lsr_w;
      logic signed [32:0] asr_w;
      logic [63:0]        ror_w;
      logic [31:0]        imm32;
      logic [63:0]        imm_w;
      logic [31:0]        fill;
      rm    = in_data.rm;
      cin   = in_data.flags[acdp_pkg::FLAG_C];
      a5    = in_data.amt[4:0];
      lsl_w = {1'b0, rm} << a5;
      lsr_w = {rm, 1'b0} >> a5;
      asr_w = $signed({rm, 1'b0}) >>> a5;
      ror_w = {rm, rm} >> a5;
      imm32 = {24'd0, in_data.imm8};
      imm_w = {imm32, imm32} >> {in_data.rot, 1'b0};
      fill  = {32{rm[31]}};

      // general case, amount 1..31 (ROR also takes the low five bits)
      case (in_data.kind)
         acdp_pkg::SH_LSL: begin
            op2 = lsl_w[31:0];
            sc  = lsl_w[32];
         end
         acdp_pkg::SH_LSR: begin
            op2 = lsr_w[32:1];
            sc  = lsr_w[0];
         end
         acdp_pkg::SH_ASR: begin
            op2 = asr_w[32:1];
            sc  = asr_w[0];
         end
         default: begin
            op2 = ror_w[31:0];
            sc  = ror_w[31];
         end
      endcase

      if (in_data.imm) begin
         op2 = imm_w[31:0];
         sc  = (in_data.rot == 4'd0) ? cin : imm_w[31];
      end else if (!in_data.reg_sh) begin
         if (a5 == 5'd0) begin
            case (in_data.kind)
               acdp_pkg::SH_LSL: begin
                  op2 = rm;
                  sc  = cin;
               end
               acdp_pkg::SH_LSR: begin
                  op2 = 32'd0;
                  sc  = rm[31];
               end
               acdp_pkg::SH_ASR: begin
                  op2 = fill;
                  sc  = rm[31];
               end
               default: begin
                  // RRX
                  op2 = {cin, rm[31:1]};
                  sc  = rm[0];
               end
            endcase
         end
      end else if (in_data.amt == 8'd0) begin
         op2 = rm;
         sc  = cin;
      end else if (in_data.amt[7:5] != 3'd0) begin
         case (in_data.kind)
            acdp_pkg::SH_LSL: begin
               op2 = 32'd0;
               sc  = (in_data.amt == 8'd32) ? rm[0] : 1'b0;
            end
            acdp_pkg::SH_LSR: begin
               op2 = 32'd0;
               sc  = (in_data.amt == 8'd32) ? rm[31] : 1'b0;
            end
            acdp_pkg::SH_ASR: begin
               op2 = fill;
               sc  = rm[31];
            end
            default: begin
               if (a5 == 5'd0) begin
                  op2 = rm;
                  sc  = rm[31];
               end
            end
         endcase
      end
   end

   always_comb begin
      data_in.dp    = in_data.dp;
      data_in.exec  = in_data.exec;
      data_in.op    = in_data.op;
      data_in.s     = in_data.s;
      data_in.rd    = in_data.rd;
      data_in.flags = in_data.flags;
      data_in.rn    = in_data.rn;
      data_in.op2   = op2;
      data_in.sc    = sc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== hdl/acdp_alu.sv =====
// ----------------------------------------------------------------------------
// acdp_alu
// Stage 3: adder and logic unit, flag update, result register.
// ----------------------------------------------------------------------------
module acdp_alu (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  acdp_pkg::opnd_type in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output acdp_pkg::rsp_type  out_data
);

   logic              valid_ff;
   logic              valid_in;
   acdp_pkg::rsp_type data_ff;
   acdp_pkg::rsp_type data_in;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;
   assign valid_in  = in_ready ? in_valid : valid_ff;

   always_comb begin
      logic [31:0] a;
      logic [31:0] b;
      logic        ci;
      logic [32:0] sum;
      logic [31:0] r;
      logic        arith;
      logic        wr;
      logic        c;
      logic        v;
      logic        cf;
      cf    = in_data.flags[acdp_pkg::FLAG_C];
      a     = in_data.rn;
      b     = in_data.op2;
      ci    = 1'b0;
      arith = 1'b1;
      wr    = 1'b1;
      case (in_data.op)
         acdp_pkg::OP_SUB, acdp_pkg::OP_CMP: begin
            b  = ~in_data.op2;
            ci = 1'b1;
         end
         acdp_pkg::OP_RSB: begin
            a  = in_data.op2;
            b  = ~in_data.rn;
            ci = 1'b1;
         end
         acdp_pkg::OP_ADC: begin
            ci = cf;
         end
         acdp_pkg::OP_SBC: begin
            b  = ~in_data.op2;
            ci = cf;
         end
         acdp_pkg::OP_RSC: begin
            a  = in_data.op2;
            b  = ~in_data.rn;
            ci = cf;
         end
         default: begin
         end
      endcase
      sum = {1'b0, a} + {1'b0, b} + {32'd0, ci};

      case (in_data.op)
         acdp_pkg::OP_AND, acdp_pkg::OP_TST: begin
            r     = in_data.rn & in_data.op2;
            arith = 1'b0;
         end
         acdp_pkg::OP_EOR, acdp_pkg::OP_TEQ: begin
            r     = in_data.rn ^ in_data.op2;
            arith = 1'b0;
         end
         acdp_pkg::OP_ORR: begin
            r     = in_data.rn | in_data.op2;
            arith = 1'b0;
         end
         acdp_pkg::OP_MOV: begin
            r     = in_data.op2;
            arith = 1'b0;
         end
         acdp_pkg::OP_BIC: begin
            r     = in_data.rn & ~in_data.op2;
            arith = 1'b0;
         end
         acdp_pkg::OP_MVN: begin
            r     = ~in_data.op2;
            arith = 1'b0;
         end
         default: begin
            r = sum[31:0];
         end
      endcase

      if (in_data.op inside {acdp_pkg::OP_TST, acdp_pkg::OP_TEQ,
                             acdp_pkg::OP_CMP, acdp_pkg::OP_CMN}) begin
         wr = 1'b0;
      end

      c = arith ? sum[32] : in_data.sc;
      v = arith ? ((a[31] ^ r[31]) & (b[31] ^ r[31])) : in_data.flags[acdp_pkg::FLAG_V];

      data_in.not_data_processing = !in_data.dp;
      data_in.executed            = in_data.exec;
      data_in.result_value        = in_data.exec ? r : 32'd0;
      data_in.write_dest          = in_data.exec && wr;
      data_in.dest_index          = in_data.dp ? in_data.rd : 4'd0;
      data_in.flags_out           = (in_data.exec && in_data.s)
                                    ? {r[31], (r == 32'd0), c, v} : in_data.flags;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   // a skipped instruction leaves the flags alone
   a_skip_flags: assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_ready && !in_data.exec) |=> (data_ff.flags_out == $past(in_data.flags)))
      else $error("flags changed by a skipped instruction");

endmodule

// ===== hdl/arm_conditional_data_processing_top.sv =====
// ----------------------------------------------------------------------------
// arm_conditional_data_processing_top
// ARMv4 data-processing execute: decode, barrel shift, ALU, flag update.
// An accepted req transaction is registered in the decode, shift and ALU
// stages, in that order, before it is offered as an rsp transaction.
// Throughput: one instruction per cycle; a full stage holds only while the
// stage after it is full and held, which starts at rsp_tready low.
// Reset: synchronous, active high; clears the stage valid bits only.
// ----------------------------------------------------------------------------
module arm_conditional_data_processing_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // instruction[31:0], rn_value[63:32], rm_value[95:64], rs_value[127:96],
   // flags_in[131:128], zero[135:132]
   input  logic [135:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // not_data_processing[0], executed[1], result_value[33:2], write_dest[34],
   // dest_index[38:35], flags_out[42:39], zero[47:43]
   output logic [47:0]  rsp_tdata
);

   acdp_pkg::req_type  req_data;
   acdp_pkg::dec_type  dec_data;
   acdp_pkg::opnd_type opnd_data;
   acdp_pkg::rsp_type  rsp_data;
   logic               dec_valid;
   logic               dec_ready;
   logic               opnd_valid;
   logic               opnd_ready;

   assign req_data  = acdp_pkg::req_type'(req_tdata[acdp_pkg::REQ_BITS-1:0]);
   assign rsp_tdata = {5'd0, rsp_data};

   acdp_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_data),
      .out_valid (dec_valid),
      .out_ready (dec_ready),
      .out_data  (dec_data)
   );

   acdp_shift u_shift (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_ready  (dec_ready),
      .in_data   (dec_data),
      .out_valid (opnd_valid),
      .out_ready (opnd_ready),
      .out_data  (opnd_data)
   );

   acdp_alu u_alu (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (opnd_valid),
      .in_ready  (opnd_ready),
      .in_data   (opnd_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_data)
   );

   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> dec_valid)
      else $error("accepted transaction missing from decode stage");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (dec_valid && opnd_valid && rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("input taken while pipeline is full and stalled");

   a_inert_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_data.executed)
         |-> (rsp_data.result_value == 32'd0 && !rsp_data.write_dest))
      else $error("skipped instruction produced a result");

   a_class_exec: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_data.not_data_processing)
         |-> (!rsp_data.executed && rsp_data.dest_index == 4'd0))
      else $error("non data-processing word marked executed");

endmodule
